// ===== design/qdp_pkg.sv =====
// package: shared constants and types of the quantized dot product core
package qdp_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic CFG_INPUT_SIGNED = 1'b0;
	localparam logic CFG_OUTPUT_MODE  = 1'b1;

	localparam logic [1:0] MODE_RELU_U8  = 2'd0;
	localparam logic [1:0] MODE_RAW      = 2'd1;
	localparam logic [1:0] MODE_CLAMP_S8 = 2'd2;

	localparam logic signed [31:0] U8_MAX = 32'sd255;
	localparam logic signed [31:0] S8_MIN = -32'sd128;
	localparam logic signed [31:0] S8_MAX = 32'sd127;

	localparam logic [63:0] S32_MAG_MIN = 64'h0000_0000_8000_0000;
	localparam logic [63:0] S32_MAX_64  = 64'h0000_0000_7FFF_FFFF;
	localparam logic [31:0] S32_MIN     = 32'h8000_0000;
	localparam logic [31:0] S32_MAX     = 32'h7FFF_FFFF;

	typedef struct packed {
		logic signed [31:0] acc;
		logic [31:0]        mult;
		logic [5:0]         shift;
		logic signed [31:0] bias;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_RND,
		BK_FIN,
		BK_OUT
	} back_state_t;

endpackage

// ===== design/qdp_front.sv =====
// front end: item intake, multiply-accumulate, hand-off of finished sums
module qdp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                input_signed,
	input  logic [7:0]          activation,
	input  logic signed [7:0]   weight,
	input  logic [31:0]         scale_mult,
	input  logic [5:0]          scale_shift,
	input  logic signed [31:0]  bias,
	input  logic                last,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                full,
	output logic                push,
	output qdp_pkg::job_t       push_job
);

	logic signed [8:0]  act_ext;
	logic signed [16:0] prod;
	logic signed [31:0] acc_sum;
	logic signed [31:0] acc_q;
	logic               fire;

	assign act_ext  = $signed({input_signed & activation[7], activation});
	assign prod     = act_ext * weight;
	assign acc_sum  = acc_q + {{15{prod[16]}}, prod};
	assign in_ready = !full;
	assign fire     = in_valid & in_ready;
	assign push     = fire & last;

	always_comb begin
		push_job.acc   = acc_sum;
		push_job.mult  = scale_mult;
		push_job.shift = scale_shift;
		push_job.bias  = bias;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (fire) begin
			if (last) begin
				acc_q <= '0;
			end else begin
				acc_q <= acc_sum;
			end
		end
	end

endmodule

// ===== design/qdp_queue.sv =====
// queue: small job queue between front and back
module qdp_queue #(
	parameter int unsigned DEPTH = qdp_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  qdp_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output qdp_pkg::job_t pop_job,
	output logic          empty
);

	localparam int unsigned PtrW = $clog2(DEPTH);
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	qdp_pkg::job_t   slot_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full    = (count_q == FullCnt);
	assign empty   = (count_q == '0);
	assign pop_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/qdp_back.sv =====
// back end: requantization sequencer, bias, output shaping and result register
module qdp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          output_mode,
	input  logic                empty,
	input  qdp_pkg::job_t       pop_job,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  result_value
);

	qdp_pkg::back_state_t state_q;
	qdp_pkg::back_state_t state_d;

	logic               neg_q;
	logic [31:0]        mag_q;
	logic [31:0]        mult_q;
	logic [5:0]         shift_q;
	logic signed [31:0] bias_q;
	logic [63:0]        prod_q;
	logic [63:0]        rnd_q;
	logic signed [31:0] result_q;

	logic [5:0]         sh_m1;
	logic [63:0]        rnd_d;
	logic [31:0]        sat;
	logic signed [31:0] z;
	logic signed [31:0] shaped;

	always_comb begin
		state_d = state_q;
		case (state_q)
			qdp_pkg::BK_IDLE: begin
				if (!empty) begin
					state_d = qdp_pkg::BK_MUL;
				end
			end
			qdp_pkg::BK_MUL: state_d = qdp_pkg::BK_RND;
			qdp_pkg::BK_RND: state_d = qdp_pkg::BK_FIN;
			qdp_pkg::BK_FIN: state_d = qdp_pkg::BK_OUT;
			qdp_pkg::BK_OUT: begin
				if (out_ready) begin
					state_d = qdp_pkg::BK_IDLE;
				end
			end
			default: state_d = qdp_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			qdp_pkg::BK_IDLE: pop       = !empty;
			qdp_pkg::BK_OUT:  out_valid = 1'b1;
			default: begin
				pop       = 1'b0;
				out_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qdp_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// round half up on the magnitude, then shift
	assign sh_m1 = shift_q - 6'd1;
	assign rnd_d = (shift_q == '0) ? prod_q : ((prod_q + (64'd1 << sh_m1)) >> shift_q);

	always_comb begin
		if (neg_q) begin
			sat = (rnd_q >= qdp_pkg::S32_MAG_MIN) ? qdp_pkg::S32_MIN : (~rnd_q[31:0] + 32'd1);
		end else begin
			sat = (rnd_q > qdp_pkg::S32_MAX_64) ? qdp_pkg::S32_MAX : rnd_q[31:0];
		end
		z = $signed(sat) + bias_q;
		case (output_mode)
			qdp_pkg::MODE_RELU_U8: begin
				if (z < 32'sd0) begin
					shaped = '0;
				end else if (z > qdp_pkg::U8_MAX) begin
					shaped = qdp_pkg::U8_MAX;
				end else begin
					shaped = z;
				end
			end
			qdp_pkg::MODE_CLAMP_S8: begin
				if (z < qdp_pkg::S8_MIN) begin
					shaped = qdp_pkg::S8_MIN;
				end else if (z > qdp_pkg::S8_MAX) begin
					shaped = qdp_pkg::S8_MAX;
				end else begin
					shaped = z;
				end
			end
			default: shaped = z;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			qdp_pkg::BK_IDLE: begin
				neg_q   <= pop_job.acc[31];
				mag_q   <= pop_job.acc[31] ? (~pop_job.acc + 32'd1) : pop_job.acc;
				mult_q  <= pop_job.mult;
				shift_q <= pop_job.shift;
				bias_q  <= pop_job.bias;
			end
			qdp_pkg::BK_MUL: prod_q   <= {32'd0, mag_q} * {32'd0, mult_q};
			qdp_pkg::BK_RND: rnd_q    <= rnd_d;
			qdp_pkg::BK_FIN: result_q <= shaped;
			default: begin
			end
		endcase
	end

	assign result_value = result_q;

endmodule

// ===== design/quantized_dot_product_requant_core.sv =====
// top level: quantized dot product with requantization, config registers and wiring
// The core accepts one activation/weight item per cycle and accumulates it in a 32-bit
// wrapping sum. An item flagged last hands its sum, multiplier, shift and bias to a
// job queue of QUEUE_DEPTH entries and clears the sum, so the next dot product starts
// in the following cycle. The back end works through one job at a time, its sequencer
// stepping through dequeue, 32x32 multiply, round and shift, saturate with bias and output
// clamp, then output register, until out_ready; items stall only while the queue is
// full. Configuration writes take effect at once and are meant for an idle core.
module quantized_dot_product_requant_core #(
	parameter int unsigned QUEUE_DEPTH = qdp_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [1:0]          cfg_data,
	input  logic [7:0]          activation,
	input  logic signed [7:0]   weight,
	input  logic [31:0]         scale_mult,
	input  logic [5:0]          scale_shift,
	input  logic signed [31:0]  bias,
	input  logic                last,
	input  logic                in_valid,
	output logic                in_ready,
	output logic signed [31:0]  result_value,
	output logic                out_valid,
	input  logic                out_ready
);

	logic          input_signed_q;
	logic [1:0]    output_mode_q;
	logic          push;
	logic          pop;
	logic          full;
	logic          empty;
	qdp_pkg::job_t push_job;
	qdp_pkg::job_t pop_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_signed_q <= 1'b0;
			output_mode_q  <= qdp_pkg::MODE_RELU_U8;
		end else if (cfg_we) begin
			case (cfg_index)
				qdp_pkg::CFG_INPUT_SIGNED: input_signed_q <= cfg_data[0];
				qdp_pkg::CFG_OUTPUT_MODE:  output_mode_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	qdp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.input_signed (input_signed_q),
		.activation   (activation),
		.weight       (weight),
		.scale_mult   (scale_mult),
		.scale_shift  (scale_shift),
		.bias         (bias),
		.last         (last),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.full         (full),
		.push         (push),
		.push_job     (push_job)
	);

	qdp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (empty)
	);

	qdp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.output_mode  (output_mode_q),
		.empty        (empty),
		.pop_job      (pop_job),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value)
	);

endmodule

// ===== bench/quantized_dot_product_requant_core_tb.sv =====
`timescale 1ns / 1ps
// testbench for the quantized dot product core: predicted requantized results checked in order

class dot_product_tracker;
	bit        act_signed;
	bit [1:0]  out_mode;
	bit [31:0] sum;
	bit [31:0] pending_results[$];
	int        errors;

	function new();
		act_signed = 1'b0;
		out_mode = qdp_pkg::MODE_RELU_U8;
		sum = '0;
		errors = 0;
	endfunction

	function void write_reg(logic index, logic [1:0] data);
		if (index == qdp_pkg::CFG_INPUT_SIGNED) begin
			act_signed = data[0];
		end else begin
			out_mode = data;
		end
	endfunction

	function bit [31:0] requantize(bit [31:0] acc, bit [31:0] mult, bit [5:0] shift);
		bit [63:0] mag;
		bit [63:0] prod;
		mag = acc[31] ? {32'd0, ~acc + 32'd1} : {32'd0, acc};
		prod = mag * {32'd0, mult};
		if (shift != 6'd0) begin
			prod = (prod + (64'd1 << (shift - 6'd1))) >> shift;
		end
		if (acc[31]) begin
			if (prod >= qdp_pkg::S32_MAG_MIN) begin
				return qdp_pkg::S32_MIN;
			end
			return ~prod[31:0] + 32'd1;
		end
		if (prod > qdp_pkg::S32_MAX_64) begin
			return qdp_pkg::S32_MAX;
		end
		return prod[31:0];
	endfunction

	function void absorb_item(bit [7:0] act, bit [7:0] wgt, bit [31:0] mult, bit [5:0] shift,
			bit [31:0] b, bit lst);
		int a;
		int w;
		int z;
		a = act_signed ? int'($signed(act)) : int'(act);
		w = int'($signed(wgt));
		sum = sum + a * w;
		if (!lst) begin
			return;
		end
		z = requantize(sum, mult, shift) + b;
		case (out_mode)
			qdp_pkg::MODE_RELU_U8: begin
				if (z < 0) begin
					z = 0;
				end else if (z > qdp_pkg::U8_MAX) begin
					z = qdp_pkg::U8_MAX;
				end
			end
			qdp_pkg::MODE_CLAMP_S8: begin
				if (z < qdp_pkg::S8_MIN) begin
					z = qdp_pkg::S8_MIN;
				end else if (z > qdp_pkg::S8_MAX) begin
					z = qdp_pkg::S8_MAX;
				end
			end
			default: begin
			end
		endcase
		pending_results.push_back(z);
		sum = '0;
	endfunction

	function void check_result(logic [31:0] got);
		bit [31:0] want;
		if (pending_results.size() == 0) begin
			errors++;
			$error("result_value: expected none, got %0d", $signed(got));
			return;
		end
		want = pending_results.pop_front();
		if (got !== want) begin
			errors++;
			$error("result_value: expected %0d, got %0d", $signed(want), $signed(got));
		end
	endfunction
endclass

module quantized_dot_product_requant_core_tb;

	localparam logic [1:0] MODE_UNDEF = 2'd3;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_ITEMS = 60;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_index;
	logic [1:0]         cfg_data;
	logic [7:0]         activation;
	logic signed [7:0]  weight;
	logic [31:0]        scale_mult;
	logic [5:0]         scale_shift;
	logic signed [31:0] bias;
	logic               last;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] result_value;
	logic               out_valid;
	logic               out_ready;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	dot_product_tracker tracker = new();

	quantized_dot_product_requant_core dut (.*);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_ready = ($urandom_range(99, 0) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			tracker.check_result(result_value);
		end
		if (!arst_n || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [7:0] act, input logic signed [7:0] wgt,
			input logic [31:0] mult, input logic [5:0] shift, input logic signed [31:0] b,
			input logic lst);
		@(negedge clk);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		activation = act;
		weight = wgt;
		scale_mult = mult;
		scale_shift = shift;
		bias = b;
		last = lst;
		in_valid = 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		tracker.absorb_item(act, wgt, mult, shift, b, lst);
	endtask

	task automatic write_reg(input logic index, input logic [1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		tracker.write_reg(index, data);
	endtask

	task automatic start_phase(input bit sgn, input logic [1:0] mode, input int spct,
			input int rpct);
		send_idle_pct = spct;
		recv_stall_pct = rpct;
		write_reg(qdp_pkg::CFG_INPUT_SIGNED, {1'b0, sgn});
		write_reg(qdp_pkg::CFG_OUTPUT_MODE, mode);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (tracker.pending_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic run_random(input int n_items);
		int sent;
		int len;
		logic [7:0] act;
		logic signed [7:0] wgt;
		logic [31:0] mult;
		logic [5:0] shift;
		logic signed [31:0] b;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 8) : $urandom_range(6, 1);
			for (int k = 1; k <= len; k++) begin
				case ($urandom_range(5, 0))
					0: act = 8'h00;
					1: act = 8'hFF;
					2: act = 8'h80;
					3: act = 8'h7F;
					default: act = 8'($urandom);
				endcase
				case ($urandom_range(4, 0))
					0: wgt = -8'sd128;
					1: wgt = 8'sd127;
					default: wgt = 8'($urandom);
				endcase
				case ($urandom_range(9, 0))
					0: begin
						mult = $urandom_range(4, 0);
						shift = 6'd0;
					end
					1: begin
						mult = $urandom;
						shift = 6'd63;
					end
					2, 3: begin
						mult = $urandom;
						shift = 6'($urandom);
					end
					default: begin
						mult = $urandom;
						shift = 6'($urandom_range(48, 26));
					end
				endcase
				case ($urandom_range(9, 0))
					0: b = qdp_pkg::S32_MAX;
					1: b = qdp_pkg::S32_MIN;
					2, 3: b = $urandom;
					default: b = $urandom_range(600, 0) - 300;
				endcase
				send_item(act, wgt, mult, shift, b, k == len);
			end
			sent += len;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = qdp_pkg::CFG_INPUT_SIGNED;
		cfg_data = '0;
		activation = '0;
		weight = '0;
		scale_mult = '0;
		scale_shift = '0;
		bias = '0;
		last = 1'b0;
		in_valid = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		start_phase(1'b0, qdp_pkg::MODE_RAW, 0, 0);
		send_item(8'hFF, -8'sd128, 32'd1, 6'd0, 32'sd0, 1'b1);
		send_item(8'hFF, 8'sd127, 32'hFFFF_FFFF, 6'd0, 32'sd0, 1'b1);
		send_item(8'hFF, -8'sd128, 32'hFFFF_FFFF, 6'd0, 32'sd0, 1'b1);
		send_item(8'h00, 8'sd0, 32'hFFFF_FFFF, 6'd63, qdp_pkg::S32_MAX, 1'b1);
		send_item(8'h01, 8'sd1, 32'd1, 6'd1, 32'sd0, 1'b1);
		send_item(8'h01, -8'sd1, 32'd3, 6'd1, 32'sd0, 1'b1);
		// bias wraps past the int32 limits
		send_item(8'hFF, 8'sd127, 32'd1, 6'd0, qdp_pkg::S32_MAX, 1'b1);
		send_item(8'hFF, -8'sd128, 32'd1, 6'd0, qdp_pkg::S32_MIN, 1'b1);
		send_item(8'hFF, 8'sd127, 32'hFFFF_FFFF, 6'd63, 32'sd0, 1'b1);
		send_item(8'hFF, -8'sd128, 32'hFFFF_FFFF, 6'd32, -32'sd5, 1'b1);
		send_item(8'h12, 8'sd100, 32'h8000_0000, 6'd20, 32'sd0, 1'b0);
		send_item(8'hC3, -8'sd77, 32'h0, 6'd0, 32'sd0, 1'b0);
		send_item(8'h5A, 8'sd33, 32'h4000_0001, 6'd30, 32'sd17, 1'b1);
		run_random(PHASE_ITEMS);
		settle();

		start_phase(1'b1, qdp_pkg::MODE_RAW, 74, 0);
		send_item(8'h80, -8'sd128, 32'd1, 6'd0, 32'sd0, 1'b1);
		send_item(8'h7F, -8'sd128, 32'd1, 6'd0, 32'sd0, 1'b1);
		send_item(8'hFF, 8'sd127, 32'd1, 6'd0, 32'sd0, 1'b1);
		send_item(8'h80, 8'sd127, 32'hFFFF_FFFF, 6'd0, 32'sd0, 1'b1);
		run_random(PHASE_ITEMS);
		settle();

		start_phase(1'b0, qdp_pkg::MODE_CLAMP_S8, 0, 74);
		run_random(PHASE_ITEMS);
		settle();
		start_phase(1'b1, MODE_UNDEF, 15, 15);
		run_random(PHASE_ITEMS);
		settle();
		start_phase(1'b1, qdp_pkg::MODE_RELU_U8, 0, 0);
		run_random(PHASE_ITEMS);
		settle();
		start_phase(1'b0, qdp_pkg::MODE_RELU_U8, 15, 15);
		run_random(PHASE_ITEMS);
		settle();
		start_phase(1'b1, qdp_pkg::MODE_CLAMP_S8, 74, 0);
		run_random(PHASE_ITEMS);
		settle();
		start_phase(1'b0, MODE_UNDEF, 0, 74);
		run_random(PHASE_ITEMS);
		settle();

		if (tracker.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
